/* sv/rhp_pkg.sv */
// Shared types and constants for the RTP header parser.
// Used by rhp_out_buf and rtp_header_parser; depends on nothing else.
`default_nettype none

package rhp_pkg;

  // Bytes in the fixed RTP header.
  localparam logic [4:0] FixedLen = 5'd12;
  // Bytes in one CSRC or extension word.
  localparam logic [3:0] WordBytes = 4'd4;

  typedef enum logic [2:0] {
    KIND_ABSORBED = 3'd0,
    KIND_HEADER   = 3'd1,
    KIND_CSRC     = 3'd2,
    KIND_EXT_HDR  = 3'd3,
    KIND_EXT_WORD = 3'd4,
    KIND_PAYLOAD  = 3'd5,
    KIND_TRUNC    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PH_FIXED     = 3'd0,
    PH_CSRC      = 3'd1,
    PH_EXT_HDR   = 3'd2,
    PH_EXT_WORDS = 3'd3,
    PH_PAYLOAD   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } rhp_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  version;
    logic        padding;
    logic        has_extension;
    logic [3:0]  csrc_count;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_res;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [31:0] word;
    logic        packet_done;
  } rhp_out_t;

endpackage

`default_nettype wire

/* sv/rhp_out_buf.sv */
// Two-entry output buffer (result register plus skid stage) for parser results.
// Depends on rhp_pkg for the result item type.
`default_nettype none

module rhp_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_stall_o,
  input  wire rhp_pkg::rhp_out_t push_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rhp_pkg::rhp_out_t     out_item_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  rhp_pkg::rhp_out_t main_q, main_d;
  rhp_pkg::rhp_out_t skid_q, skid_d;
  logic              push, pop, main_free;

  assign push_stall_o = skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_item_o   = main_q;

  assign push      = push_valid_i && !skid_valid_q;
  assign pop       = main_valid_q && !out_stall_i;
  assign main_free = !main_valid_q || pop;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        // The skid stage drains first; no push can happen while it is full.
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = push_item_i;
        main_valid_d = push;
      end
    end else if (push) begin
      skid_d       = push_item_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

`ifndef ASSERT_OFF
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid stage holds an item while the result register is empty");

  a_skid_drains_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (main_valid_q && !skid_valid_q && main_q == $past(skid_q)))
    else $error("skid item was not moved into the result register");
`endif

endmodule

`default_nettype wire

/* sv/rtp_header_parser.sv */
// RTP header parser top level: byte-wise header state and result formation.
// Depends on rhp_pkg and rhp_out_buf.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------
//   input   | in_valid_i / in_stall_o    | in_item_i  (rhp_pkg::rhp_in_t)
//   output  | out_valid_o / out_stall_i  | out_item_o (rhp_pkg::rhp_out_t)
//
// One byte is accepted per cycle while in_stall_o is low; each byte yields exactly one result item,
// which is offered on the output from the cycle after acceptance unless
// earlier items are still waiting there.
// The result register and a one-entry skid stage set the throughput: input is
// stalled only while both hold an item.
// Reset returns the parser to the start of a fixed header and empties both
// output entries; every end-of-packet byte does the same to the parse state.
`default_nettype none

module rtp_header_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire rhp_pkg::rhp_in_t in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rhp_pkg::rhp_out_t     out_item_o
);

  rhp_pkg::phase_e   phase_q, phase_d;
  logic [3:0]        byte_count_q, byte_count_d;
  logic [7:0]        first_byte_q, first_byte_d;
  logic [7:0]        second_byte_q, second_byte_d;
  logic [15:0]       seq_q, seq_d;
  logic [31:0]       stamp_q, stamp_d;
  logic [31:0]       ssrc_q, ssrc_d;
  logic [31:0]       word_accum_q, word_accum_d;
  logic [3:0]        csrc_left_q, csrc_left_d;
  logic [15:0]       ext_left_q, ext_left_d;

  logic              accept;
  logic [7:0]        b;
  logic              eop;
  logic [4:0]        pos_next;
  logic [31:0]       acc;
  logic [3:0]        bc_next;
  logic              hdr;
  rhp_pkg::kind_e    kind;
  logic [31:0]       w;
  rhp_pkg::rhp_out_t res;
  rhp_pkg::phase_e   after_csrc;

  assign accept = in_valid_i && !in_stall_o;
  assign b      = in_item_i.data_byte;
  assign eop    = in_item_i.end_of_packet;

  always_comb begin
    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    first_byte_d  = first_byte_q;
    second_byte_d = second_byte_q;
    seq_d         = seq_q;
    stamp_d       = stamp_q;
    ssrc_d        = ssrc_q;
    word_accum_d  = word_accum_q;
    csrc_left_d   = csrc_left_q;
    ext_left_d    = ext_left_q;
    kind          = rhp_pkg::KIND_ABSORBED;
    w             = 32'd0;
    hdr           = 1'b0;
    pos_next      = {1'b0, byte_count_q} + 5'd1;
    acc           = {word_accum_q[23:0], b};
    bc_next       = byte_count_q + 4'd1;
    after_csrc    = first_byte_q[4] ? rhp_pkg::PH_EXT_HDR : rhp_pkg::PH_PAYLOAD;

    case (phase_q)
      rhp_pkg::PH_PAYLOAD: begin
        kind = rhp_pkg::KIND_PAYLOAD;
        w    = {24'd0, b};
      end
      rhp_pkg::PH_CSRC, rhp_pkg::PH_EXT_HDR, rhp_pkg::PH_EXT_WORDS: begin
        if (bc_next >= rhp_pkg::WordBytes) begin
          w            = acc;
          byte_count_d = 4'd0;
          word_accum_d = 32'd0;
          case (phase_q)
            rhp_pkg::PH_CSRC: begin
              kind        = rhp_pkg::KIND_CSRC;
              csrc_left_d = csrc_left_q - 4'd1;
              if (csrc_left_d == 4'd0) begin
                phase_d = after_csrc;
              end
            end
            rhp_pkg::PH_EXT_HDR: begin
              kind       = rhp_pkg::KIND_EXT_HDR;
              ext_left_d = acc[15:0];
              phase_d    = (acc[15:0] != 16'd0) ? rhp_pkg::PH_EXT_WORDS
                                                : rhp_pkg::PH_PAYLOAD;
            end
            default: begin
              kind       = rhp_pkg::KIND_EXT_WORD;
              ext_left_d = ext_left_q - 16'd1;
              if (ext_left_d == 16'd0) begin
                phase_d = rhp_pkg::PH_PAYLOAD;
              end
            end
          endcase
        end else begin
          word_accum_d = acc;
          byte_count_d = bc_next;
        end
      end
      default: begin
        // Fixed header; unused phase codes behave the same way.
        case (byte_count_q)
          4'd0:                      first_byte_d  = b;
          4'd1:                      second_byte_d = b;
          4'd2, 4'd3:                seq_d   = {seq_q[7:0], b};
          4'd4, 4'd5, 4'd6, 4'd7:    stamp_d = {stamp_q[23:0], b};
          default:                   ssrc_d  = {ssrc_q[23:0], b};
        endcase
        if (pos_next >= rhp_pkg::FixedLen) begin
          kind         = rhp_pkg::KIND_HEADER;
          hdr          = 1'b1;
          csrc_left_d  = first_byte_d[3:0];
          byte_count_d = 4'd0;
          word_accum_d = 32'd0;
          if (first_byte_d[3:0] != 4'd0) begin
            phase_d = rhp_pkg::PH_CSRC;
          end else begin
            phase_d = first_byte_d[4] ? rhp_pkg::PH_EXT_HDR : rhp_pkg::PH_PAYLOAD;
          end
        end else begin
          phase_d      = rhp_pkg::PH_FIXED;
          byte_count_d = pos_next[3:0];
        end
      end
    endcase

    // A packet that ends while header bytes are still owed is truncated.
    if (eop && phase_d != rhp_pkg::PH_PAYLOAD) begin
      kind = rhp_pkg::KIND_TRUNC;
      w    = 32'd0;
      hdr  = 1'b0;
    end

    res               = '0;
    res.kind          = kind;
    res.word          = w;
    res.packet_done   = eop;
    if (hdr) begin
      res.version       = first_byte_d[7:6];
      res.padding       = first_byte_d[5];
      res.has_extension = first_byte_d[4];
      res.csrc_count    = first_byte_d[3:0];
      res.marker        = second_byte_d[0];
      res.payload_type  = second_byte_d[7:1];
      res.sequence_res  = seq_d;
      res.time_stamp    = stamp_d;
      res.source_id     = ssrc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= rhp_pkg::PH_FIXED;
      byte_count_q <= 4'd0;
    end else if (accept) begin
      if (eop) begin
        phase_q      <= rhp_pkg::PH_FIXED;
        byte_count_q <= 4'd0;
      end else begin
        phase_q      <= phase_d;
        byte_count_q <= byte_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_byte_q  <= first_byte_d;
      second_byte_q <= second_byte_d;
      seq_q         <= seq_d;
      stamp_q       <= stamp_d;
      ssrc_q        <= ssrc_d;
      word_accum_q  <= word_accum_d;
      csrc_left_q   <= csrc_left_d;
      ext_left_q    <= ext_left_d;
    end
  end

  rhp_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_item_i  (res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

`ifndef ASSERT_OFF
  a_fixed_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rhp_pkg::PH_FIXED |-> {1'b0, byte_count_q} < rhp_pkg::FixedLen)
    else $error("fixed header byte count out of range");

  a_word_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rhp_pkg::PH_CSRC || phase_q == rhp_pkg::PH_EXT_HDR ||
     phase_q == rhp_pkg::PH_EXT_WORDS) |-> byte_count_q < rhp_pkg::WordBytes)
    else $error("word byte count out of range");

  a_eop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eop) |=> (phase_q == rhp_pkg::PH_FIXED && byte_count_q == 4'd0))
    else $error("parser did not restart after end of packet");

  a_header_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.kind != rhp_pkg::KIND_HEADER) |->
      (out_item_o.version == 2'd0 && out_item_o.csrc_count == 4'd0 &&
       out_item_o.source_id == 32'd0 && out_item_o.time_stamp == 32'd0))
    else $error("header fields set on a non-header item");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for rtp_header_parser: random and directed RTP packets
// are streamed byte by byte and every result item is checked against a predictor.
// Depends on rhp_pkg and the rtp_header_parser RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int DirectedItems = 25;
  localparam int RandomItems   = 2000;
  localparam int CycleLimit    = 400000;
  localparam int HoldAt        = 200;
  localparam int HoldCycles    = 300;
  localparam int DrainSpacing  = 700;
  localparam int SettleCycles  = 20;

  typedef struct packed {
    rhp_pkg::rhp_in_t item;
    logic             drain;
  } pending_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rhp_pkg::rhp_in_t  in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rhp_pkg::rhp_out_t out_item;

  pending_t          pending_q[$];
  rhp_pkg::rhp_out_t expected_q[$];
  logic [7:0]        pkt_bytes[$];

  int  total_items = 0;
  int  n_accepted = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  accepted = 1'b0;

  // Parser state mirrored by the predictor.
  rhp_pkg::phase_e ps_phase;
  logic [3:0]      ps_count;
  logic [7:0]      ps_first;
  logic [7:0]      ps_second;
  logic [15:0]     ps_seq;
  logic [31:0]     ps_stamp;
  logic [31:0]     ps_ssrc;
  logic [31:0]     ps_accum;
  logic [3:0]      ps_csrc_left;
  logic [15:0]     ps_ext_left;

  rtp_header_parser u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void parser_clear();
    ps_phase     = rhp_pkg::PH_FIXED;
    ps_count     = '0;
    ps_first     = '0;
    ps_second    = '0;
    ps_seq       = '0;
    ps_stamp     = '0;
    ps_ssrc      = '0;
    ps_accum     = '0;
    ps_csrc_left = '0;
    ps_ext_left  = '0;
  endfunction

  function automatic void enter_ext_or_payload();
    if (ps_first[4]) begin
      ps_phase = rhp_pkg::PH_EXT_HDR;
    end else begin
      ps_phase = rhp_pkg::PH_PAYLOAD;
    end
    ps_count = '0;
    ps_accum = '0;
  endfunction

  // Advances the parser by one byte and returns the result item it should give.
  function automatic rhp_pkg::rhp_out_t parse_byte(rhp_pkg::rhp_in_t it);
    rhp_pkg::rhp_out_t r;
    logic              hdr;
    logic [4:0]        pos;
    r      = '0;
    r.kind = rhp_pkg::KIND_ABSORBED;
    hdr    = 1'b0;
    case (ps_phase)
      rhp_pkg::PH_PAYLOAD: begin
        r.kind = rhp_pkg::KIND_PAYLOAD;
        r.word = {24'd0, it.data_byte};
      end
      rhp_pkg::PH_CSRC, rhp_pkg::PH_EXT_HDR, rhp_pkg::PH_EXT_WORDS: begin
        ps_accum = {ps_accum[23:0], it.data_byte};
        ps_count = ps_count + 4'd1;
        if (ps_count >= rhp_pkg::WordBytes) begin
          r.word   = ps_accum;
          ps_count = '0;
          ps_accum = '0;
          if (ps_phase == rhp_pkg::PH_CSRC) begin
            r.kind       = rhp_pkg::KIND_CSRC;
            ps_csrc_left = ps_csrc_left - 4'd1;
            if (ps_csrc_left == 4'd0) enter_ext_or_payload();
          end else if (ps_phase == rhp_pkg::PH_EXT_HDR) begin
            r.kind      = rhp_pkg::KIND_EXT_HDR;
            ps_ext_left = r.word[15:0];
            if (ps_ext_left != 16'd0) begin
              ps_phase = rhp_pkg::PH_EXT_WORDS;
            end else begin
              ps_phase = rhp_pkg::PH_PAYLOAD;
            end
          end else begin
            r.kind      = rhp_pkg::KIND_EXT_WORD;
            ps_ext_left = ps_ext_left - 16'd1;
            if (ps_ext_left == 16'd0) ps_phase = rhp_pkg::PH_PAYLOAD;
          end
        end
      end
      default: begin
        pos = {1'b0, ps_count};
        if (pos == 5'd0) begin
          ps_first = it.data_byte;
        end else if (pos == 5'd1) begin
          ps_second = it.data_byte;
        end else if (pos < 5'd4) begin
          ps_seq = {ps_seq[7:0], it.data_byte};
        end else if (pos < 5'd8) begin
          ps_stamp = {ps_stamp[23:0], it.data_byte};
        end else begin
          ps_ssrc = {ps_ssrc[23:0], it.data_byte};
        end
        pos = pos + 5'd1;
        if (pos >= rhp_pkg::FixedLen) begin
          r.kind       = rhp_pkg::KIND_HEADER;
          hdr          = 1'b1;
          ps_csrc_left = ps_first[3:0];
          if (ps_csrc_left != 4'd0) begin
            ps_phase = rhp_pkg::PH_CSRC;
            ps_count = '0;
            ps_accum = '0;
          end else begin
            enter_ext_or_payload();
          end
        end else begin
          ps_phase = rhp_pkg::PH_FIXED;
          ps_count = pos[3:0];
        end
      end
    endcase

    // A packet that ends while header bytes are still owed is truncated.
    if (it.end_of_packet && ps_phase != rhp_pkg::PH_PAYLOAD) begin
      r.kind = rhp_pkg::KIND_TRUNC;
      r.word = '0;
      hdr    = 1'b0;
    end
    if (hdr) begin
      r.version       = ps_first[7:6];
      r.padding       = ps_first[5];
      r.has_extension = ps_first[4];
      r.csrc_count    = ps_first[3:0];
      r.marker        = ps_second[0];
      r.payload_type  = ps_second[7:1];
      r.sequence_res  = ps_seq;
      r.time_stamp    = ps_stamp;
      r.source_id     = ps_ssrc;
    end
    r.packet_done = it.end_of_packet;
    if (it.end_of_packet) parser_clear();
    return r;
  endfunction

  function automatic int sender_idle_pct();
    if (n_accepted < total_items / 3) return 21;
    if (n_accepted < 2 * total_items / 3) return 56;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_accepted < total_items / 3) return 56;
    if (n_accepted < 2 * total_items / 3) return 21;
    return 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Appends one byte to the packet under construction.
  task automatic add_byte(input logic [7:0] value);
    pkt_bytes.insert(pkt_bytes.size(), value);
  endtask

  // Moves the bytes in pkt_bytes to the pending queue, marking the last as end of packet.
  task automatic queue_packet(input bit drain_first);
    pending_t p;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      p.item.data_byte     = pkt_bytes[i];
      p.item.end_of_packet = (i == pkt_bytes.size() - 1);
      p.drain              = drain_first && (i == 0);
      pending_q.insert(pending_q.size(), p);
    end
    pkt_bytes.delete();
  endtask

  // A well-formed packet; with wild set the extension length is random and the
  // words that follow fall short of it.
  task automatic build_packet(input bit wild);
    logic [7:0]  b0;
    logic [15:0] ext_len;
    int          n_csrc;
    int          n_words;
    int          n_pay;
    b0 = 8'($urandom);
    if ($urandom_range(3) != 0) b0[7:6] = 2'b10;
    if (wild) b0[4] = 1'b1;
    n_csrc = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
    b0[3:0] = 4'(n_csrc);
    add_byte(b0);
    repeat (11) add_byte(8'($urandom));
    repeat (4 * n_csrc) add_byte(8'($urandom));
    if (b0[4]) begin
      ext_len = wild ? 16'($urandom) : 16'($urandom_range(3));
      n_words = wild ? $urandom_range(2) : int'(ext_len);
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      add_byte(ext_len[15:8]);
      add_byte(ext_len[7:0]);
      repeat (4 * n_words) add_byte(8'($urandom));
    end
    n_pay = ($urandom_range(3) == 0) ? 0 : $urandom_range(16, 1);
    repeat (n_pay) add_byte(8'($urandom));
  endtask

  // Sender: a new item is offered only once the previous one has been taken.
  always @(negedge clk) begin : driver
    logic             next_valid;
    rhp_pkg::rhp_in_t next_item;
    pending_t         head;
    next_valid = in_valid;
    next_item  = in_item;
    if (rst_n && (!in_valid || accepted)) begin
      next_valid = 1'b0;
      if (pending_q.size() != 0) begin
        head = pending_q[0];
        if (!(head.drain && expected_q.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct()) begin
          head       = pending_q.pop_front();
          next_valid = 1'b1;
          next_item  = head.item;
        end
      end
    end
    accepted = 1'b0;
    in_valid <= next_valid;
    in_item  <= next_item;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the parser.
  always @(negedge clk) begin : receiver
    logic next_stall;
    if (hold_left != 0) begin
      next_stall = 1'b1;
      hold_left--;
    end else if (!hold_done && n_accepted >= HoldAt) begin
      next_stall = 1'b1;
      hold_left  = HoldCycles - 1;
      hold_done  = 1'b1;
    end else begin
      next_stall = $urandom_range(99) < receiver_idle_pct();
    end
    out_stall <= next_stall;
  end

  // Results are checked before this edge's accepted byte is predicted.
  always @(posedge clk) begin : monitor
    rhp_pkg::rhp_out_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        if (out_valid && !out_stall) begin
          if (expected_q.size() == 0) begin
            $error("result item with no expectation waiting");
            mismatches++;
          end else begin
            want = expected_q.pop_front();
            check_field("kind", 32'(want.kind), 32'(out_item.kind));
            check_field("version", 32'(want.version), 32'(out_item.version));
            check_field("padding", 32'(want.padding), 32'(out_item.padding));
            check_field("has_extension", 32'(want.has_extension),
                        32'(out_item.has_extension));
            check_field("csrc_count", 32'(want.csrc_count), 32'(out_item.csrc_count));
            check_field("marker", 32'(want.marker), 32'(out_item.marker));
            check_field("payload_type", 32'(want.payload_type),
                        32'(out_item.payload_type));
            check_field("sequence_res", 32'(want.sequence_res),
                        32'(out_item.sequence_res));
            check_field("time_stamp", want.time_stamp, out_item.time_stamp);
            check_field("source_id", want.source_id, out_item.source_id);
            check_field("word", want.word, out_item.word);
            check_field("packet_done", 32'(want.packet_done), 32'(out_item.packet_done));
          end
        end
        if (in_valid && !in_stall) begin
          expected_q.insert(expected_q.size(), parse_byte(in_item));
          n_accepted++;
          accepted = 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int sel;
    int keep;
    int next_drain;
    bit drain;
    parser_clear();

    // One-byte packet: truncated at once, and the next byte starts afresh.
    add_byte(8'hFF);
    queue_packet(1'b0);
    // Full header with padding, one CSRC and a one-word extension, ending on the
    // byte that completes the header.
    pkt_bytes = '{8'hB1, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78};
    queue_packet(1'b0);

    next_drain = pending_q.size();
    while (pending_q.size() < DirectedItems + RandomItems) begin
      drain = pending_q.size() >= next_drain;
      if (drain) next_drain += DrainSpacing;
      sel = $urandom_range(99);
      if (sel < 75) begin
        build_packet(1'b0);
      end else if (sel < 90) begin
        build_packet(1'($urandom_range(1)));
        keep = $urandom_range(pkt_bytes.size() - 1, 1);
        while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
      end else begin
        repeat ($urandom_range(20, 1)) add_byte(8'($urandom));
      end
      queue_packet(drain);
    end
    total_items = pending_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (n_accepted < total_items || expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
